// File: design/kta_pkg.sv
// Shared constants, codes and controller/datapath interface types for the texture animator.
`timescale 1ns / 1ps
`default_nettype none
package kta_pkg;
	localparam int MAX_KEYS   = 64;
	localparam int KEY_IDX_W  = 6;
	localparam int TRK_W      = 2;
	localparam int ADDR_W     = TRK_W + KEY_IDX_W;
	localparam int SLOTS      = 4 * MAX_KEYS;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_POS_CNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_CNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_CNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FPS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LEN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_TEX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSED    = 3'd7;

	localparam logic [TRK_W-1:0] TRK_POS   = 2'd0;
	localparam logic [TRK_W-1:0] TRK_SCALE = 2'd1;
	localparam logic [TRK_W-1:0] TRK_ROT   = 2'd2;
	localparam logic [TRK_W-1:0] TRK_TEX   = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [15:0] FPS_RESET = 16'd7680;
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] Q_HALF    = 32'h0000_8000;

	typedef struct packed {
		logic key_wr;
		logic tick_ld;
		logic mod_step;
		logic clk_st;
		logic fpos_ld;
		logic trk_first;
		logic trk_next;
		logic dflt;
		logic scan_init;
		logic scan;
		logic sel;
		logic frac_init;
		logic frac_step;
		logic rd_b;
		logic lat_a;
		logic mul;
		logic acc;
	} cmd_t;

	typedef struct packed {
		logic paused;
		logic len_zero;
		logic mod_last;
		logic trk_empty;
		logic scan_done;
		logic frac_last;
		logic trk_last;
	} sts_t;
endpackage
`default_nettype wire

// File: design/kta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/kta_ctrl.sv
// Sequencing state machine for key writes and ticks.
`timescale 1ns / 1ps
`default_nettype none
module kta_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire            opcode,
	input  kta_pkg::sts_t  sts,
	output kta_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MOD   = 4'd1;
	localparam logic [3:0] ST_STORE = 4'd2;
	localparam logic [3:0] ST_FPOS  = 4'd3;
	localparam logic [3:0] ST_TRK   = 4'd4;
	localparam logic [3:0] ST_SCAN  = 4'd5;
	localparam logic [3:0] ST_SEL   = 4'd6;
	localparam logic [3:0] ST_FINIT = 4'd7;
	localparam logic [3:0] ST_FDIV  = 4'd8;
	localparam logic [3:0] ST_RDA   = 4'd9;
	localparam logic [3:0] ST_RDB   = 4'd10;
	localparam logic [3:0] ST_MUL   = 4'd11;
	localparam logic [3:0] ST_ACC   = 4'd12;
	localparam logic [3:0] ST_NEXT  = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == kta_pkg::OP_WRITE) begin
						cmd.key_wr = 1'b1;
					end else if (!sts.paused) begin
						if (sts.len_zero) begin
							state_d = ST_FPOS;
						end else begin
							cmd.tick_ld = 1'b1;
							state_d = ST_MOD;
						end
					end
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.clk_st = 1'b1;
				state_d = ST_FPOS;
			end
			ST_FPOS: begin
				cmd.fpos_ld = 1'b1;
				cmd.trk_first = 1'b1;
				state_d = ST_TRK;
			end
			ST_TRK: begin
				if (sts.trk_empty) begin
					cmd.dflt = 1'b1;
					state_d = ST_NEXT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_FINIT;
			end
			ST_FINIT: begin
				cmd.frac_init = 1'b1;
				state_d = ST_FDIV;
			end
			ST_FDIV: begin
				cmd.frac_step = 1'b1;
				if (sts.frac_last) state_d = ST_RDA;
			end
			ST_RDA: begin
				state_d = ST_RDB;
			end
			ST_RDB: begin
				cmd.rd_b = 1'b1;
				cmd.lat_a = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (sts.trk_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.trk_next = 1'b1;
					state_d = ST_TRK;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
endmodule
`default_nettype wire

// File: design/kta_dpath.sv
// Datapath: registers, key memories, clock wrap, key search, fraction divider and blend.
`timescale 1ns / 1ps
`default_nettype none
module kta_dpath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  kta_pkg::cmd_t                     cmd,
	output kta_pkg::sts_t                     sts,
	input  wire                               wr_en,
	input  wire [kta_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire [31:0]                        wr_data,
	input  wire [1:0]                         track,
	input  wire [5:0]                         key_index,
	input  wire [15:0]                        key_frame,
	input  wire signed [31:0]                 value_a,
	input  wire signed [31:0]                 value_b,
	input  wire signed [31:0]                 value_c,
	input  wire [31:0]                        delta_time,
	output logic signed [31:0]                pos_x,
	output logic signed [31:0]                pos_y,
	output logic signed [31:0]                pos_z,
	output logic signed [31:0]                scale_x,
	output logic signed [31:0]                scale_y,
	output logic signed [31:0]                rotation,
	output logic signed [31:0]                pivot_x,
	output logic signed [31:0]                pivot_y,
	output logic [15:0]                       texture_id
);
	// configuration
	logic [kta_pkg::CNT_W-1:0] cnt_q [4];
	logic [15:0] fps_q;
	logic [31:0] len_q;
	logic [15:0] def_tex_q;
	logic        paused_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0]  <= '0;
			cnt_q[1]  <= '0;
			cnt_q[2]  <= '0;
			cnt_q[3]  <= '0;
			fps_q     <= kta_pkg::FPS_RESET;
			len_q     <= '0;
			def_tex_q <= '0;
			paused_q  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				kta_pkg::CFG_POS_CNT:   cnt_q[0]  <= wr_data[kta_pkg::CNT_W-1:0];
				kta_pkg::CFG_SCALE_CNT: cnt_q[1]  <= wr_data[kta_pkg::CNT_W-1:0];
				kta_pkg::CFG_ROT_CNT:   cnt_q[2]  <= wr_data[kta_pkg::CNT_W-1:0];
				kta_pkg::CFG_TEX_CNT:   cnt_q[3]  <= wr_data[kta_pkg::CNT_W-1:0];
				kta_pkg::CFG_FPS:       fps_q     <= wr_data[15:0];
				kta_pkg::CFG_LOOP_LEN:  len_q     <= wr_data;
				kta_pkg::CFG_DEF_TEX:   def_tex_q <= wr_data[15:0];
				kta_pkg::CFG_PAUSED:    paused_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// clock wrap: restoring remainder, one bit per cycle
	logic [31:0] clock_q;
	logic [32:0] mod_sum_q;
	logic [31:0] mod_rem_q;
	logic [5:0]  mod_cnt_q;
	logic [32:0] mod_try;
	logic [47:0] fpos_q;
	logic [23:0] frame;

	assign mod_try = {mod_rem_q, mod_sum_q[32]};
	assign frame   = fpos_q[47:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (cmd.clk_st) begin
			clock_q <= mod_rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_ld) begin
			mod_sum_q <= {1'b0, clock_q} + {1'b0, delta_time};
			mod_rem_q <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			mod_sum_q <= {mod_sum_q[31:0], 1'b0};
			mod_cnt_q <= mod_cnt_q + 6'd1;
			if (mod_try >= {1'b0, len_q}) begin
				mod_rem_q <= 32'(mod_try - {1'b0, len_q});
			end else begin
				mod_rem_q <= mod_try[31:0];
			end
		end
		if (cmd.fpos_ld) begin
			fpos_q <= (len_q == '0) ? '0 : {16'd0, clock_q} * {32'd0, fps_q};
		end
	end

	// track walk
	logic [kta_pkg::TRK_W-1:0] trk_q;
	logic [kta_pkg::CNT_W-1:0] n_cur;

	assign n_cur = (cnt_q[trk_q] > 7'(kta_pkg::MAX_KEYS)) ? 7'(kta_pkg::MAX_KEYS) : cnt_q[trk_q];

	always_ff @(posedge clk) begin
		if (cmd.trk_first) begin
			trk_q <= kta_pkg::TRK_POS;
		end else if (cmd.trk_next) begin
			trk_q <= trk_q + 2'd1;
		end
	end

	// key memories
	logic [kta_pkg::ADDR_W-1:0] waddr, raddr;
	logic [15:0] fr_rd;
	logic [31:0] val_rd [3];
	logic [31:0] val_wr [3];
	logic [kta_pkg::CNT_W-1:0] scan_cnt_q;
	logic [kta_pkg::KEY_IDX_W-1:0] sel_a_q, sel_b_q;

	assign waddr = {track, key_index};
	assign val_wr[0] = value_a;
	assign val_wr[1] = value_b;
	assign val_wr[2] = value_c;

	always_comb begin
		if (cmd.scan) begin
			raddr = {trk_q, scan_cnt_q[kta_pkg::KEY_IDX_W-1:0]};
		end else if (cmd.rd_b) begin
			raddr = {trk_q, sel_b_q};
		end else begin
			raddr = {trk_q, sel_a_q};
		end
	end

	kta_ram #(.WIDTH(16), .DEPTH(kta_pkg::SLOTS)) u_frames (
		.clk(clk), .we(cmd.key_wr), .waddr(waddr), .wdata(key_frame),
		.raddr(raddr), .rdata(fr_rd)
	);

	for (genvar g = 0; g < 3; g++) begin : g_val
		kta_ram #(.WIDTH(32), .DEPTH(kta_pkg::SLOTS)) u_vals (
			.clk(clk), .we(cmd.key_wr), .waddr(waddr), .wdata(val_wr[g]),
			.raddr(raddr), .rdata(val_rd[g])
		);
	end

	// bracketing search, one key per cycle, compared from the registered RAM read data
	logic                          iss_s1;
	logic [kta_pkg::KEY_IDX_W-1:0] idx_s1;
	logic                          found_q;
	logic [kta_pkg::KEY_IDX_W-1:0] prev_q, next_q;
	logic [15:0]                   kf0_q, kflast_q, kfprev_q, kfnext_q;
	logic [kta_pkg::CNT_W-1:0]     n_m1;

	assign n_m1 = n_cur - 7'd1;

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			scan_cnt_q <= '0;
			iss_s1     <= 1'b0;
			found_q    <= 1'b0;
			prev_q     <= '0;
			next_q     <= '0;
		end else if (cmd.scan) begin
			if (scan_cnt_q < n_cur) begin
				iss_s1     <= 1'b1;
				idx_s1     <= scan_cnt_q[kta_pkg::KEY_IDX_W-1:0];
				scan_cnt_q <= scan_cnt_q + 7'd1;
			end else begin
				iss_s1 <= 1'b0;
			end
			if (iss_s1) begin
				if (idx_s1 == '0) kf0_q <= fr_rd;
				if (idx_s1 == n_m1[kta_pkg::KEY_IDX_W-1:0]) kflast_q <= fr_rd;
				if (!found_q) begin
					if ({8'd0, fr_rd} > frame) begin
						found_q  <= 1'b1;
						next_q   <= idx_s1;
						kfnext_q <= fr_rd;
					end else begin
						prev_q   <= idx_s1;
						kfprev_q <= fr_rd;
					end
				end
			end
		end
	end

	// selection and blend fraction
	logic        copy_q;
	logic [47:0] offset_q;
	logic [15:0] den_q;
	logic [47:0] div_rem_q;
	logic [38:0] div_d_q;
	logic        sat_q;
	logic [15:0] quo_q;
	logic [3:0]  div_cnt_q;
	logic [15:0] frac;

	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			// frame position past the previous key, Q24 fraction kept
			offset_q <= fpos_q - {8'd0, kfprev_q, 24'd0};
			den_q    <= kfnext_q - kfprev_q;
			if ({8'd0, kflast_q} <= frame) begin
				sel_a_q <= n_m1[kta_pkg::KEY_IDX_W-1:0];
				sel_b_q <= n_m1[kta_pkg::KEY_IDX_W-1:0];
				copy_q  <= 1'b1;
			end else if ({8'd0, kf0_q} > frame) begin
				sel_a_q <= '0;
				sel_b_q <= '0;
				copy_q  <= 1'b1;
			end else if (trk_q == kta_pkg::TRK_TEX) begin
				sel_a_q <= prev_q;
				sel_b_q <= prev_q;
				copy_q  <= 1'b1;
			end else begin
				sel_a_q <= prev_q;
				sel_b_q <= next_q;
				copy_q  <= 1'b0;
			end
		end
		if (cmd.frac_init) begin
			div_rem_q <= offset_q;
			div_d_q   <= {den_q, 23'd0};
			sat_q     <= offset_q >= {8'd0, den_q, 24'd0};
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.frac_step) begin
			if (div_rem_q >= {9'd0, div_d_q}) begin
				div_rem_q <= div_rem_q - {9'd0, div_d_q};
				quo_q     <= {quo_q[14:0], 1'b1};
			end else begin
				quo_q     <= {quo_q[14:0], 1'b0};
			end
			div_d_q   <= div_d_q >> 1;
			div_cnt_q <= div_cnt_q + 4'd1;
		end
	end

	assign frac = copy_q ? 16'd0 : (sat_q ? 16'hFFFF : quo_q);

	// blend: a + floor((b - a) * frac / 2^16), three lanes
	logic signed [31:0] a_q [3];
	logic signed [49:0] prod_q [3];
	logic signed [31:0] res [3];

	for (genvar g = 0; g < 3; g++) begin : g_blend
		logic signed [32:0] diff;
		assign diff   = {val_rd[g][31], val_rd[g]} - {a_q[g][31], a_q[g]};
		assign res[g] = a_q[g] + prod_q[g][47:16];
		always_ff @(posedge clk) begin
			if (cmd.lat_a) a_q[g] <= val_rd[g];
			if (cmd.mul) prod_q[g] <= diff * $signed({1'b0, frac});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			case (trk_q)
				kta_pkg::TRK_POS: begin
					pos_x <= res[0]; pos_y <= res[1]; pos_z <= res[2];
				end
				kta_pkg::TRK_SCALE: begin
					scale_x <= res[0]; scale_y <= res[1];
				end
				kta_pkg::TRK_ROT: begin
					rotation <= res[0]; pivot_x <= res[1]; pivot_y <= res[2];
				end
				default: texture_id <= res[0][15:0];
			endcase
		end else if (cmd.dflt) begin
			case (trk_q)
				kta_pkg::TRK_POS: begin
					pos_x <= '0; pos_y <= '0; pos_z <= '0;
				end
				kta_pkg::TRK_SCALE: begin
					scale_x <= kta_pkg::Q_ONE; scale_y <= kta_pkg::Q_ONE;
				end
				kta_pkg::TRK_ROT: begin
					rotation <= '0; pivot_x <= kta_pkg::Q_HALF; pivot_y <= kta_pkg::Q_HALF;
				end
				default: texture_id <= def_tex_q;
			endcase
		end
	end

	assign sts.paused    = paused_q;
	assign sts.len_zero  = (len_q == '0);
	assign sts.mod_last  = (mod_cnt_q == 6'd32);
	assign sts.trk_empty = (n_cur == '0);
	assign sts.scan_done = (scan_cnt_q == n_cur) && !iss_s1;
	assign sts.frac_last = (div_cnt_q == 4'd15);
	assign sts.trk_last  = (trk_q == kta_pkg::TRK_TEX);
endmodule
`default_nettype wire

// File: design/keyframe_texture_transform_animator.sv
// Top level of the keyframe texture transform animator.
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy is low. A key write
// (opcode 0) is stored in that same cycle and leaves busy low, so writes can
// come back to back. A tick (opcode 1), unless paused, raises busy and ends
// with done high for exactly one cycle while the nine result ports hold the
// new transform; the receiver cannot stall, so sample them on done. A paused
// tick gives no done and leaves busy low. A tick runs the one-bit-per-cycle
// loop wrap and the clock store (skipped when the loop length is zero), then
// for each track that holds keys reads one key frame per cycle from the key
// memory during the search and runs a 16-step divider for the blend fraction;
// an empty track takes its default values instead.
// Configuration writes are accepted at any time busy is low.
module keyframe_texture_transform_animator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	output logic                         done,
	input  wire                          wr_en,
	input  wire [kta_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire [31:0]                   wr_data,
	input  wire                          opcode,
	input  wire [1:0]                    track,
	input  wire [5:0]                    key_index,
	input  wire [15:0]                   key_frame,
	input  wire signed [31:0]            value_a,
	input  wire signed [31:0]            value_b,
	input  wire signed [31:0]            value_c,
	input  wire [31:0]                   delta_time,
	output logic signed [31:0]           pos_x,
	output logic signed [31:0]           pos_y,
	output logic signed [31:0]           pos_z,
	output logic signed [31:0]           scale_x,
	output logic signed [31:0]           scale_y,
	output logic signed [31:0]           rotation,
	output logic signed [31:0]           pivot_x,
	output logic signed [31:0]           pivot_y,
	output logic [15:0]                  texture_id
);
	kta_pkg::cmd_t cmd;
	kta_pkg::sts_t sts;

	// sequencing: one state per phase of a tick
	kta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.sts(sts), .cmd(cmd), .busy(busy), .done(done)
	);

	// registers, key memories and arithmetic
	kta_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.track(track), .key_index(key_index), .key_frame(key_frame),
		.value_a(value_a), .value_b(value_b), .value_c(value_c),
		.delta_time(delta_time),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.scale_x(scale_x), .scale_y(scale_y),
		.rotation(rotation), .pivot_x(pivot_x), .pivot_y(pivot_y),
		.texture_id(texture_id)
	);
endmodule
`default_nettype wire
